// ----- src/rtc_calendar_log_scheduler_macros.svh -----
// Assertion macros for the RTC calendar and log scheduler
`ifndef RTC_CALENDAR_LOG_SCHEDULER_MACROS_SVH
`define RTC_CALENDAR_LOG_SCHEDULER_MACROS_SVH

// same-cycle implication, clocked on clk, held off while rst_n is low
`define RTCL_ASSERT_IMP(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define RTCL_ASSERT_NXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ----- src/rtcl_pkg.sv -----
// Types, codes and tables shared by the RTC calendar and log scheduler
package rtcl_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_ARM  = 2'd2;

    localparam logic [1:0] UNIT_HOUR   = 2'd0;
    localparam logic [1:0] UNIT_MINUTE = 2'd1;
    localparam logic [1:0] UNIT_SECOND = 2'd2;
    localparam logic [1:0] UNIT_TICK   = 2'd3;

    localparam logic [1:0] REG_LOG_UNIT     = 2'd0;
    localparam logic [1:0] REG_LOG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_SECS_TO_LOG  = 2'd2;
    localparam logic [1:0] REG_TICKS_PER_S  = 2'd3;

    localparam logic [1:0]  RST_LOG_UNIT     = 2'd1;
    localparam logic [6:0]  RST_LOG_INTERVAL = 7'd10;
    localparam logic [15:0] RST_SECS_TO_LOG  = 16'd60;
    localparam logic [7:0]  RST_TICKS_PER_S  = 8'd1;

    localparam logic [4:0] RST_HOUR  = 5'd12;
    localparam logic [4:0] RST_DAY   = 5'd5;
    localparam logic [3:0] RST_MONTH = 4'd12;
    localparam logic [6:0] RST_YEAR  = 7'd3;

    localparam logic [6:0] SEC_LIMIT  = 7'd60;
    localparam logic [6:0] MIN_MAX    = 7'd59;
    localparam logic [5:0] HOUR_MAX   = 6'd23;
    localparam logic [4:0] MONTH_MAX  = 5'd12;
    localparam logic [7:0] YEAR_MAX   = 8'd99;
    localparam logic [3:0] FEBRUARY   = 4'd2;
    localparam logic [6:0] LEAP_MASK  = 7'h03;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] pulse_count;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
        logic [5:0]  new_second;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [6:0]  new_year;
    } in_word_t;

    typedef struct packed {
        logic [6:0]  tick_now;
        logic [5:0]  second_now;
        logic [5:0]  minute_now;
        logic [4:0]  hour_now;
        logic [4:0]  day_now;
        logic [3:0]  month_now;
        logic [6:0]  year_now;
        logic        logging_armed;
        logic        speed_window_open;
        logic        log_now;
        logic [15:0] speed_total_out;
        logic [15:0] last_speed;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] value;
    } cfg_word_t;

    typedef struct packed {
        logic        armed;
        logic        window;
        logic [6:0]  interval_count;
        logic [15:0] pulse_sum;
        logic [15:0] window_seconds;
    } log_state_t;

    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
            4'd2:                                     len = 5'd28;
            default:                                  len = 5'd0;
        endcase
        return len;
    endfunction

    // one step of the interval counter; a full interval opens the window
    function automatic log_state_t step_interval(input log_state_t s,
                                                 input logic [6:0] interval);
        log_state_t r;
        logic [7:0] cnt;
        r   = s;
        cnt = {1'b0, s.interval_count} + 8'd1;
        if (s.armed && (interval != 7'd0)) begin
            if (cnt >= {1'b0, interval}) begin
                r.window         = 1'b1;
                r.pulse_sum      = 16'd0;
                r.interval_count = 7'd0;
                r.window_seconds = 16'd0;
                r.armed          = 1'b0;
            end
            else begin
                r.interval_count = cnt[6:0];
            end
        end
        return r;
    endfunction

endpackage

// ----- src/rtcl_in_if.sv -----
// Input word channel of the RTC calendar and log scheduler
interface rtcl_in_if;
    import rtcl_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/rtcl_out_if.sv -----
// Result word channel of the RTC calendar and log scheduler
interface rtcl_out_if;
    import rtcl_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/rtcl_cfg_if.sv -----
// Configuration write channel of the RTC calendar and log scheduler
interface rtcl_cfg_if;
    import rtcl_pkg::*;
    logic      valid;
    logic      ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/rtc_calendar_log_scheduler.sv -----
// Real-time clock calendar with interval speed-logging scheduler (top level)
//
// Channels: item takes command words (tick, load time and date, arm logging);
// result returns one word per item with the time, date and logging status
// after that item; cfg writes the four scheduler registers by index and is
// always ready.
// The result word is registered and valid the cycle after its item is accepted.
// Throughput: one word per cycle while result.ready is high; the whole calendar carry chain,
// interval counter and window compare sit between the state registers and the result
// register, so every item is finished in the cycle it is taken.
// item.ready is high while the result register is empty or being emptied.
// Stall: if result.ready is low the held word stays put and item.ready drops
// until it is taken; nothing is lost or repeated.
// Reset: 12:00:00 on day 5, month 12, year 3, logging disarmed, window
// closed, totals zero; registers return to unit minute, interval 10,
// window 60 s, one tick per second. No result is pending after reset.
`include "rtc_calendar_log_scheduler_macros.svh"

module rtc_calendar_log_scheduler (
    input  logic      clk,
    input  logic      rst_n,
    rtcl_in_if.sink   item,
    rtcl_out_if.source result,
    rtcl_cfg_if.sink  cfg
);
    import rtcl_pkg::*;

    logic [1:0]  log_unit_reg;
    logic [6:0]  log_interval_reg;
    logic [15:0] secs_to_log_reg;
    logic [7:0]  ticks_per_s_reg;

    logic [6:0]  tick_reg, tick_next;
    logic [5:0]  second_reg, second_next;
    logic [5:0]  minute_reg, minute_next;
    logic [4:0]  hour_reg, hour_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [6:0]  year_reg, year_next;
    log_state_t  log_reg, log_next;
    logic [15:0] speed_reg, speed_next;
    logic        log_now_next;

    out_word_t   out_reg;
    logic        out_valid_reg;
    logic        take;

    assign item.ready   = !out_valid_reg || result.ready;
    assign take         = item.valid && item.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_unit_reg     <= RST_LOG_UNIT;
            log_interval_reg <= RST_LOG_INTERVAL;
            secs_to_log_reg  <= RST_SECS_TO_LOG;
            ticks_per_s_reg  <= RST_TICKS_PER_S;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_LOG_UNIT:     log_unit_reg     <= cfg.data.value[1:0];
                REG_LOG_INTERVAL: log_interval_reg <= cfg.data.value[6:0];
                REG_SECS_TO_LOG:  secs_to_log_reg  <= cfg.data.value;
                REG_TICKS_PER_S:  ticks_per_s_reg  <= cfg.data.value[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        logic [7:0] limit;
        logic [7:0] tick_inc;
        logic [6:0] sec_inc;
        logic [6:0] min_inc;
        logic [5:0] hour_inc;
        logic [5:0] day_inc;
        logic [5:0] len;
        logic [4:0] month_inc;
        logic [7:0] year_inc;
        logic       sec_end;
        logic       min_roll;
        logic       hour_roll;
        logic       step_now;
        logic [15:0] prev_ws;

        tick_next    = tick_reg;
        second_next  = second_reg;
        minute_next  = minute_reg;
        hour_next    = hour_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        log_next     = log_reg;
        speed_next   = speed_reg;
        log_now_next = 1'b0;

        limit     = (ticks_per_s_reg == 8'd0) ? 8'd1 : ticks_per_s_reg;
        tick_inc  = {1'b0, tick_reg} + 8'd1;
        sec_inc   = {1'b0, second_reg} + 7'd1;
        min_inc   = {1'b0, minute_reg} + 7'd1;
        hour_inc  = {1'b0, hour_reg} + 6'd1;
        day_inc   = {1'b0, day_reg} + 6'd1;
        month_inc = {1'b0, month_reg} + 5'd1;
        year_inc  = {1'b0, year_reg} + 8'd1;
        len       = {1'b0, month_days(month_reg)};
        if ((month_reg == FEBRUARY) && ((year_reg & LEAP_MASK) == 7'd0))
        begin
            len = len + 6'd1;
        end
        sec_end   = 1'b0;
        min_roll  = 1'b0;
        hour_roll = 1'b0;
        step_now  = 1'b0;
        prev_ws   = log_reg.window_seconds;

        unique case (item.data.cmd)
            CMD_TICK:
            begin
                if (tick_inc >= limit)
                begin
                    tick_next = 7'd0;
                    sec_end   = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc[6:0];
                end

                if (sec_end)
                begin
                    speed_next = item.data.pulse_count;
                    if (sec_inc >= SEC_LIMIT)
                    begin
                        second_next = 6'd0;
                        min_roll    = 1'b1;
                        if (min_inc > MIN_MAX)
                        begin
                            minute_next = 6'd0;
                            hour_roll   = 1'b1;
                            if (hour_inc > HOUR_MAX)
                            begin
                                hour_next = 5'd0;
                                if (day_inc > len)
                                begin
                                    day_next = 5'd1;
                                    if (month_inc > MONTH_MAX)
                                    begin
                                        month_next = 4'd1;
                                        year_next  = (year_inc > YEAR_MAX) ?
                                                     7'd0 : year_inc[6:0];
                                    end
                                    else
                                    begin
                                        month_next = month_inc[3:0];
                                    end
                                end
                                else
                                begin
                                    day_next = day_inc[4:0];
                                end
                            end
                            else
                            begin
                                hour_next = hour_inc[4:0];
                            end
                        end
                        else
                        begin
                            minute_next = min_inc[5:0];
                        end
                    end
                    else
                    begin
                        second_next = sec_inc[5:0];
                    end

                    step_now = ((log_unit_reg == UNIT_HOUR) && hour_roll) ||
                               ((log_unit_reg == UNIT_MINUTE) && min_roll) ||
                               (log_unit_reg == UNIT_SECOND);
                    if (step_now)
                    begin
                        log_next = step_interval(log_next, log_interval_reg);
                    end
                    log_next.pulse_sum = log_next.pulse_sum + speed_next;
                    if (log_next.window)
                    begin
                        prev_ws                 = log_next.window_seconds;
                        log_next.window_seconds = prev_ws + 16'd1;
                        if (prev_ws >= secs_to_log_reg)
                        begin
                            log_next.armed  = 1'b1;
                            log_next.window = 1'b0;
                            log_now_next    = 1'b1;
                        end
                    end
                end

                // tick unit: the window opens and closes on the same tick
                if (log_unit_reg == UNIT_TICK)
                begin
                    log_next = step_interval(log_next, log_interval_reg);
                    if (log_next.window)
                    begin
                        log_next.armed  = 1'b1;
                        log_next.window = 1'b0;
                        log_now_next    = 1'b1;
                    end
                end
            end
            CMD_LOAD:
            begin
                hour_next   = item.data.new_hour;
                minute_next = item.data.new_minute;
                second_next = item.data.new_second;
                day_next    = item.data.new_day;
                month_next  = item.data.new_month;
                year_next   = item.data.new_year;
            end
            CMD_ARM:
            begin
                log_next.armed = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= 7'd0;
            second_reg <= 6'd0;
            minute_reg <= 6'd0;
            hour_reg   <= RST_HOUR;
            day_reg    <= RST_DAY;
            month_reg  <= RST_MONTH;
            year_reg   <= RST_YEAR;
            log_reg    <= '0;
            speed_reg  <= 16'd0;
        end
        else if (take)
        begin
            tick_reg   <= tick_next;
            second_reg <= second_next;
            minute_reg <= minute_next;
            hour_reg   <= hour_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            log_reg    <= log_next;
            speed_reg  <= speed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            out_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.tick_now          <= tick_next;
            out_reg.second_now        <= second_next;
            out_reg.minute_now        <= minute_next;
            out_reg.hour_now          <= hour_next;
            out_reg.day_now           <= day_next;
            out_reg.month_now         <= month_next;
            out_reg.year_now          <= year_next;
            out_reg.logging_armed     <= log_next.armed;
            out_reg.speed_window_open <= log_next.window;
            out_reg.log_now           <= log_now_next;
            out_reg.speed_total_out   <= log_next.pulse_sum;
            out_reg.last_speed        <= speed_next;
        end
    end

    `RTCL_ASSERT_NXT(a_word_follows, take, result.valid,
        "accepted word did not reach the result register")
    `RTCL_ASSERT_IMP(a_log_rearms, result.valid && result.data.log_now,
        result.data.logging_armed && !result.data.speed_window_open,
        "log pulse without re-arm and window close")
    `RTCL_ASSERT_NXT(a_unit_write, cfg.valid && cfg.ready &&
        (cfg.data.index == REG_LOG_UNIT),
        log_unit_reg == $past(cfg.data.value[1:0]),
        "log unit write not taken")

endmodule

// ----- tb/sv/rtc_calendar_log_scheduler_checker.sv -----
// Result predictor and comparator for the RTC calendar and log scheduler
module rtc_calendar_log_scheduler_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  rtcl_pkg::in_word_t  item_data,
    input  logic               result_valid,
    input  logic               result_ready,
    input  rtcl_pkg::out_word_t result_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  rtcl_pkg::cfg_word_t cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import rtcl_pkg::*;

    logic [1:0]  unit_q;
    logic [6:0]  interval_q;
    logic [15:0] window_len_q;
    logic [7:0]  tps_q;

    logic [6:0]  tick_q;
    logic [5:0]  sec_q;
    logic [5:0]  min_q;
    logic [4:0]  hour_q;
    logic [4:0]  day_q;
    logic [3:0]  mon_q;
    logic [6:0]  year_q;
    logic [6:0]  icount_q;
    logic        armed_q;
    logic        window_q;
    logic [15:0] psum_q;
    logic [15:0] wsec_q;
    logic [15:0] speed_q;

    out_word_t   expected_words[$];
    out_word_t   want_w;
    out_word_t   next_w;

    function automatic int month_length(input logic [3:0] month);
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
            4'd4, 4'd6, 4'd9, 4'd11:                  return 30;
            4'd2:                                     return 28;
            default:                                  return 0;
        endcase
    endfunction

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
            report($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endtask

    task automatic step_log_interval();
        if (armed_q && interval_q != 7'd0)
        begin
            if (int'(icount_q) + 1 >= int'(interval_q))
            begin
                window_q = 1'b1;
                psum_q   = 16'd0;
                icount_q = 7'd0;
                wsec_q   = 16'd0;
                armed_q  = 1'b0;
            end
            else
            begin
                icount_q = icount_q + 7'd1;
            end
        end
    endtask

    task automatic advance_date();
        int len;
        int d;
        len = month_length(mon_q);
        if (mon_q == FEBRUARY && year_q[1:0] == 2'b00)
            len++;
        d = int'(day_q) + 1;
        if (d > len)
        begin
            d = 1;
            if (mon_q >= 4'd12)
            begin
                mon_q  = 4'd1;
                year_q = (year_q >= 7'd99) ? 7'd0 : year_q + 7'd1;
            end
            else
            begin
                mon_q = mon_q + 4'd1;
            end
        end
        day_q = d[4:0];
    endtask

    task automatic advance_second(input logic [15:0] pulses, output logic closed);
        logic [15:0] prev;
        closed  = 1'b0;
        speed_q = pulses;
        if (sec_q >= 6'd59)
        begin
            sec_q = 6'd0;
            if (min_q >= 6'd59)
            begin
                min_q = 6'd0;
                if (hour_q >= 5'd23)
                begin
                    hour_q = 5'd0;
                    advance_date();
                end
                else
                begin
                    hour_q = hour_q + 5'd1;
                end
                if (unit_q == UNIT_HOUR)
                    step_log_interval();
            end
            else
            begin
                min_q = min_q + 6'd1;
            end
            if (unit_q == UNIT_MINUTE)
                step_log_interval();
        end
        else
        begin
            sec_q = sec_q + 6'd1;
        end
        if (unit_q == UNIT_SECOND)
            step_log_interval();
        psum_q = psum_q + speed_q;
        if (window_q)
        begin
            prev   = wsec_q;
            wsec_q = wsec_q + 16'd1;
            if (prev >= window_len_q)
            begin
                armed_q  = 1'b1;
                window_q = 1'b0;
                closed   = 1'b1;
            end
        end
    endtask

    task automatic predict_word(input in_word_t w, output out_word_t r);
        logic log_pulse;
        int   limit;
        log_pulse = 1'b0;
        case (w.cmd)
            CMD_TICK:
            begin
                limit = (tps_q == 8'd0) ? 1 : int'(tps_q);
                if (int'(tick_q) + 1 >= limit)
                begin
                    tick_q = 7'd0;
                    advance_second(w.pulse_count, log_pulse);
                end
                else
                begin
                    tick_q = tick_q + 7'd1;
                end
                if (unit_q == UNIT_TICK)
                begin
                    step_log_interval();
                    if (window_q)
                    begin
                        armed_q   = 1'b1;
                        window_q  = 1'b0;
                        log_pulse = 1'b1;
                    end
                end
            end
            CMD_LOAD:
            begin
                hour_q = w.new_hour;
                min_q  = w.new_minute;
                sec_q  = w.new_second;
                day_q  = w.new_day;
                mon_q  = w.new_month;
                year_q = w.new_year;
            end
            CMD_ARM:
            begin
                armed_q = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.tick_now          = tick_q;
        r.second_now        = sec_q;
        r.minute_now        = min_q;
        r.hour_now          = hour_q;
        r.day_now           = day_q;
        r.month_now         = mon_q;
        r.year_now          = year_q;
        r.logging_armed     = armed_q;
        r.speed_window_open = window_q;
        r.log_now           = log_pulse;
        r.speed_total_out   = psum_q;
        r.last_speed        = speed_q;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_q       = RST_LOG_UNIT;
            interval_q   = RST_LOG_INTERVAL;
            window_len_q = RST_SECS_TO_LOG;
            tps_q        = RST_TICKS_PER_S;
            tick_q       = 7'd0;
            sec_q        = 6'd0;
            min_q        = 6'd0;
            hour_q       = RST_HOUR;
            day_q        = RST_DAY;
            mon_q        = RST_MONTH;
            year_q       = RST_YEAR;
            icount_q     = 7'd0;
            armed_q      = 1'b0;
            window_q     = 1'b0;
            psum_q       = 16'd0;
            wsec_q       = 16'd0;
            speed_q      = 16'd0;
            expected_words.delete();
            fail_count   = 0;
            pending      = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report("result word with nothing expected");
                end
                else
                begin
                    want_w = expected_words.pop_front();
                    check_field("tick_now", 16'(want_w.tick_now),
                                16'(result_data.tick_now));
                    check_field("second_now", 16'(want_w.second_now),
                                16'(result_data.second_now));
                    check_field("minute_now", 16'(want_w.minute_now),
                                16'(result_data.minute_now));
                    check_field("hour_now", 16'(want_w.hour_now),
                                16'(result_data.hour_now));
                    check_field("day_now", 16'(want_w.day_now),
                                16'(result_data.day_now));
                    check_field("month_now", 16'(want_w.month_now),
                                16'(result_data.month_now));
                    check_field("year_now", 16'(want_w.year_now),
                                16'(result_data.year_now));
                    check_field("logging_armed", 16'(want_w.logging_armed),
                                16'(result_data.logging_armed));
                    check_field("speed_window_open", 16'(want_w.speed_window_open),
                                16'(result_data.speed_window_open));
                    check_field("log_now", 16'(want_w.log_now),
                                16'(result_data.log_now));
                    check_field("speed_total_out", want_w.speed_total_out,
                                result_data.speed_total_out);
                    check_field("last_speed", want_w.last_speed, result_data.last_speed);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.index)
                    REG_LOG_UNIT:     unit_q       = cfg_data.value[1:0];
                    REG_LOG_INTERVAL: interval_q   = cfg_data.value[6:0];
                    REG_SECS_TO_LOG:  window_len_q = cfg_data.value;
                    REG_TICKS_PER_S:  tps_q        = cfg_data.value[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (item_valid && item_ready)
            begin
                predict_word(item_data, next_w);
                expected_words.push_back(next_w);
            end
            pending = expected_words.size();
        end
    end

endmodule

// ----- tb/sv/rtc_calendar_log_scheduler_test.sv -----
// Stimulus and verdict for the RTC calendar and log scheduler
module rtc_calendar_log_scheduler_test;
    import rtcl_pkg::*;

    localparam logic [1:0] CMD_IDLE   = 2'd3;
    localparam int         N_SETUPS   = 7;
    localparam int         SETUP_WORDS = 205;
    localparam int         LONG_HOLD  = 300;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   hold_requests;
    int   fail_count;
    int   pending;

    rtcl_in_if  item_if ();
    rtcl_out_if result_if ();
    rtcl_cfg_if cfg_if ();

    rtc_calendar_log_scheduler uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    rtc_calendar_log_scheduler_checker ref_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_if.valid),
        .item_ready   (item_if.ready),
        .item_data    (item_if.data),
        .result_valid (result_if.valid),
        .result_ready (result_if.ready),
        .result_data  (result_if.data),
        .cfg_valid    (cfg_if.valid),
        .cfg_ready    (cfg_if.ready),
        .cfg_data     (cfg_if.data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    function automatic in_word_t cmd_word(input logic [1:0] cmd, input logic [15:0] pulses);
        in_word_t w;
        w             = '0;
        w.cmd         = cmd;
        w.pulse_count = pulses;
        return w;
    endfunction

    function automatic in_word_t load_word(input int h, input int mi, input int se,
                                           input int d, input int mo, input int y);
        in_word_t w;
        w            = '0;
        w.cmd        = CMD_LOAD;
        w.new_hour   = 5'(h);
        w.new_minute = 6'(mi);
        w.new_second = 6'(se);
        w.new_day    = 5'(d);
        w.new_month  = 4'(mo);
        w.new_year   = 7'(y);
        return w;
    endfunction

    // mostly ticks; loads land near carries so the calendar rolls often
    function automatic in_word_t random_word();
        in_word_t    w;
        logic [63:0] raw;
        int unsigned pick;
        raw  = {$urandom, $urandom};
        w    = raw[$bits(in_word_t)-1:0];
        pick = $urandom_range(99);
        if (pick < 70) begin
            w.cmd = CMD_TICK;
            case ($urandom_range(9))
                0:       w.pulse_count = 16'h0000;
                1:       w.pulse_count = 16'hFFFF;
                default: ;
            endcase
        end
        else if (pick < 82) begin
            w.cmd = CMD_LOAD;
            if ($urandom_range(3) != 0) begin
                w.new_hour   = $urandom_range(1) ? 5'd23 : 5'($urandom_range(23));
                w.new_minute = $urandom_range(2) ? 6'd59 : 6'($urandom_range(59));
                w.new_second = 6'($urandom_range(59, 50));
                w.new_day    = 5'($urandom_range(31, 27));
                w.new_month  = 4'($urandom_range(12, 1));
                w.new_year   = ($urandom_range(3) == 0) ? 7'd99 : 7'($urandom_range(99));
            end
        end
        else if (pick < 94) begin
            w.cmd = CMD_ARM;
        end
        else begin
            w.cmd = CMD_IDLE;
        end
        return w;
    endfunction

    task automatic send_item(input in_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid = 1'b0;
            @(negedge clk);
        end
        item_if.valid = 1'b1;
        item_if.data  = w;
        do @(posedge clk); while (!item_if.ready);
    endtask

    task automatic drain();
        @(negedge clk);
        item_if.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = {index, value};
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin : result_sink
        int hold_left;
        int seen;
        hold_left       = 0;
        seen            = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (seen != hold_requests) begin
                seen      = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready = 1'b0;
            end
            else begin
                result_if.ready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin : stimulus
        logic [1:0]  unit;
        logic [15:0] interval;
        logic [15:0] window_len;
        logic [15:0] tps;
        rst_n         = 1'b0;
        item_if.valid = 1'b0;
        item_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        src_idle_pct  = 8;
        sink_idle_pct = 80;
        hold_requests = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: totals wrap, leap and non-leap February,
        // year wrap, out-of-range loads repaired, invalid months, unused command
        send_item(cmd_word(CMD_TICK, 16'h0000));
        send_item(cmd_word(CMD_TICK, 16'hFFFF));
        send_item(cmd_word(CMD_TICK, 16'hFFFF));
        send_item(cmd_word(CMD_ARM, 16'h1234));
        send_item(load_word(23, 59, 58, 28, 2, 99));
        send_item(cmd_word(CMD_TICK, 16'h00FF));
        send_item(cmd_word(CMD_TICK, 16'hFF00));
        send_item(load_word(23, 59, 59, 31, 12, 99));
        send_item(cmd_word(CMD_TICK, 16'h5555));
        send_item(load_word(23, 59, 59, 28, 2, 96));
        send_item(cmd_word(CMD_TICK, 16'hAAAA));
        send_item(load_word(31, 63, 63, 31, 15, 127));
        send_item(cmd_word(CMD_TICK, 16'h0001));
        send_item(load_word(23, 59, 59, 0, 0, 100));
        send_item(cmd_word(CMD_TICK, 16'h8000));
        send_item(load_word(23, 59, 59, 31, 12, 100));
        send_item(cmd_word(CMD_TICK, 16'h7FFF));
        send_item(cmd_word(CMD_IDLE, 16'hFFFF));

        for (int s = 0; s < N_SETUPS; s++) begin
            if (s == 2) begin
                src_idle_pct  = 80;
                sink_idle_pct = 8;
            end
            else if (s == 4) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (s)
                0:       begin unit = UNIT_SECOND; interval = 3;   window_len = 4;     tps = 1;   end
                1:       begin unit = UNIT_TICK;   interval = 2;   window_len = 0;     tps = 3;   end
                2:       begin unit = UNIT_MINUTE; interval = 1;   window_len = 2;     tps = 1;   end
                3:       begin unit = UNIT_HOUR;   interval = 1;   window_len = 65535; tps = 1;   end
                4:       begin unit = UNIT_TICK;   interval = 127; window_len = 7;     tps = 128; end
                5:       begin unit = UNIT_SECOND; interval = 0;   window_len = 0;     tps = 0;   end
                default: begin unit = UNIT_TICK;   interval = 5;   window_len = 3;     tps = 255; end
            endcase
            drain();
            write_reg(REG_LOG_UNIT, {14'd0, unit});
            write_reg(REG_LOG_INTERVAL, interval);
            write_reg(REG_SECS_TO_LOG, window_len);
            write_reg(REG_TICKS_PER_S, tps);
            for (int n = 0; n < SETUP_WORDS; n++) begin
                if ((s == 1 || s == 5) && n == 60)
                    hold_requests++;
                send_item(random_word());
            end
        end

        drain();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("rtc_calendar_log_scheduler verification clean");
        else
            $display("rtc_calendar_log_scheduler verification failed");
        $finish;
    end

    initial begin : watchdog
        #600000;
        $display("rtc_calendar_log_scheduler verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/rtcl_pkg.sv
src/rtcl_in_if.sv
src/rtcl_out_if.sv
src/rtcl_cfg_if.sv
src/rtc_calendar_log_scheduler.sv
tb/sv/rtc_calendar_log_scheduler_checker.sv
tb/sv/rtc_calendar_log_scheduler_test.sv
